// ===== rtl/core/hatp_pkg.sv =====
`timescale 1ns / 1ps

package hatp_pkg;

    localparam int COORD_W = 12;
    localparam int DEG_W   = 9;
    localparam int K_W     = 7;
    localparam int ANG_N   = 128;
    localparam int TAB_W   = 63;

    localparam logic [K_W-1:0] K_MAX   = K_W'(89);
    localparam logic [K_W-1:0] K_EXACT = K_W'(45);

    localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
    localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
    localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270);
    localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360);

    typedef struct packed {
        logic [COORD_W-1:0] front_x;
        logic [COORD_W-1:0] front_y;
        logic [COORD_W-1:0] back_x;
        logic [COORD_W-1:0] back_y;
    } t_item;

    typedef struct packed {
        logic [DEG_W-1:0] heading_deg;
        logic             heading_valid;
    } t_result;

    typedef struct packed {
        logic dx_zero;
        logic dx_neg;
        logic dy_zero;
        logic dy_neg;
    } t_side;

    // Q1.62 trig tables (Q2.62 arithmetic), built at elaboration
    typedef logic [63:0] t_q62;
    typedef logic [ANG_N-1:0][TAB_W-1:0] t_trig_tab;

    localparam t_q62 Q62_ONE = 64'h4000_0000_0000_0000;
    localparam t_q62 PI_Q62  = 64'hC90F_DAA2_2168_C234;
    localparam t_q62 DEG_Q62 = PI_Q62 / 64'd180;

    localparam t_q62 SIN_DIV [1:10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                        64'd156, 64'd210, 64'd272, 64'd342, 64'd420};
    localparam t_q62 COS_DIV [1:10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                        64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

    function automatic t_q62 mulq(input t_q62 x, input t_q62 y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    function automatic t_trig_tab build_trig(input logic want_sin);
        t_q62      x2;
        t_q62      s;
        t_q62      c;
        t_q62      ts;
        t_q62      tc;
        t_q62      cv;
        t_q62      sv;
        t_q62      cn;
        t_q62      sn;
        t_trig_tab tab;
        x2 = mulq(DEG_Q62, DEG_Q62);
        s  = DEG_Q62;
        c  = Q62_ONE;
        ts = DEG_Q62;
        tc = Q62_ONE;
        for (int n = 1; n <= 10; n++) begin
            ts = mulq(ts, x2) / SIN_DIV[n];
            tc = mulq(tc, x2) / COS_DIV[n];
            if (n[0]) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        tab = '0;
        cv  = Q62_ONE;
        sv  = '0;
        for (int k = 0; k <= 90; k++) begin
            tab[k] = want_sin ? sv[TAB_W-1:0] : cv[TAB_W-1:0];
            cn = mulq(cv, c) - mulq(sv, s);
            sn = mulq(sv, c) + mulq(cv, s);
            cv = cn;
            sv = sn;
        end
        return tab;
    endfunction

    localparam t_trig_tab COS_TAB = build_trig(1'b0);
    localparam t_trig_tab SIN_TAB = build_trig(1'b1);

endpackage

// ===== rtl/core/hatp_front.sv =====
`timescale 1ns / 1ps

module hatp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  hatp_pkg::t_item              i_item,
    output logic                         o_valid,
    output logic [hatp_pkg::COORD_W-1:0] o_a,
    output logic [hatp_pkg::COORD_W-1:0] o_b,
    output hatp_pkg::t_side              o_side
);
    import hatp_pkg::*;

    logic [COORD_W-1:0] fx, fy, bx, by;
    logic [COORD_W-1:0] n_a, n_b;
    t_side              n_side;

    logic               r_valid;
    logic [COORD_W-1:0] r_a, r_b;
    t_side              r_side;

    assign fx = i_item.front_x;
    assign fy = i_item.front_y;
    assign bx = i_item.back_x;
    assign by = i_item.back_y;

    always_comb begin
        n_side.dx_zero = (fx == bx);
        n_side.dx_neg  = (fx < bx);
        n_side.dy_zero = (fy == by);
        n_side.dy_neg  = (fy < by);
        n_a = n_side.dy_neg ? (by - fy) : (fy - by);
        n_b = n_side.dx_neg ? (bx - fx) : (fx - bx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_side <= n_side;
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_side  = r_side;

endmodule

// ===== rtl/core/hatp_cell.sv =====
`timescale 1ns / 1ps

// Decides one bit of the truncated angle: keeps the candidate when
// it is at most K_MAX and a*cos(k) >= b*sin(k).
module hatp_cell #(
    parameter int BIT = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [hatp_pkg::COORD_W-1:0] i_a,
    input  logic [hatp_pkg::COORD_W-1:0] i_b,
    input  logic [hatp_pkg::K_W-1:0]     i_k,
    input  hatp_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [hatp_pkg::COORD_W-1:0] o_a,
    output logic [hatp_pkg::COORD_W-1:0] o_b,
    output logic [hatp_pkg::K_W-1:0]     o_k,
    output hatp_pkg::t_side              o_side
);
    import hatp_pkg::*;

    localparam int             PROD_W = COORD_W + TAB_W;
    localparam logic [K_W-1:0] STEP   = K_W'(1) << BIT;

    logic [K_W-1:0]     cand;
    logic               pred;
    logic [K_W-1:0]     n_k;

    // multiply stage
    logic               r_v1;
    logic [COORD_W-1:0] r_a1, r_b1;
    logic [K_W-1:0]     r_k1, r_cand1;
    logic               r_use1, r_exact1;
    t_side              r_side1;
    logic [PROD_W-1:0]  r_pa1, r_pb1;

    // compare stage
    logic               r_v2;
    logic [COORD_W-1:0] r_a2, r_b2;
    logic [K_W-1:0]     r_k2;
    t_side              r_side2;

    assign cand = i_k | STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1     <= i_a;
        r_b1     <= i_b;
        r_k1     <= i_k;
        r_cand1  <= cand;
        r_use1   <= (cand <= K_MAX);
        r_exact1 <= (cand == K_EXACT);
        r_side1  <= i_side;
        r_pa1    <= PROD_W'(i_a) * PROD_W'(COS_TAB[cand]);
        r_pb1    <= PROD_W'(i_b) * PROD_W'(SIN_TAB[cand]);
    end

    // 45 degrees is decided exactly
    assign pred = r_exact1 ? (r_a1 >= r_b1) : (r_pa1 >= r_pb1);
    assign n_k  = (r_use1 && pred) ? r_cand1 : r_k1;

    always_ff @(posedge i_clk) begin
        r_a2    <= r_a1;
        r_b2    <= r_b1;
        r_k2    <= n_k;
        r_side2 <= r_side1;
    end

    assign o_valid = r_v2;
    assign o_a     = r_a2;
    assign o_b     = r_b2;
    assign o_k     = r_k2;
    assign o_side  = r_side2;

endmodule

// ===== rtl/core/hatp_back.sv =====
`timescale 1ns / 1ps

module hatp_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [hatp_pkg::K_W-1:0] i_k,
    input  hatp_pkg::t_side          i_side,
    output logic                     o_strobe,
    output hatp_pkg::t_result        o_result
);
    import hatp_pkg::*;

    logic [DEG_W-1:0] k_ext;
    t_result          n_result;

    logic             r_strobe;
    t_result          r_result;

    assign k_ext = DEG_W'(i_k);

    always_comb begin
        n_result.heading_valid = 1'b1;
        if (i_side.dx_zero && i_side.dy_zero) begin
            n_result.heading_deg   = '0;
            n_result.heading_valid = 1'b0;
        end else if (i_side.dx_zero) begin
            n_result.heading_deg = i_side.dy_neg ? DEG_270 : DEG_90;
        end else if (i_side.dx_neg) begin
            n_result.heading_deg = i_side.dy_neg ? (DEG_180 + k_ext) : (DEG_180 - k_ext);
        end else if (i_side.dy_neg || i_side.dy_zero) begin
            n_result.heading_deg = DEG_360 - k_ext;
        end else begin
            n_result.heading_deg = k_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/core/heading_angle_from_two_points.sv =====
`timescale 1ns / 1ps

// Channel | Ports                  | Handshake
// --------+------------------------+-------------------------------------
// in      | i_item                 | taken when start && !busy
// out     | o_result               | o_strobe high for one cycle, no stall
//
// One item per cycle while busy is low; the pipe has one stage for
// the deltas, two per search cell (multiply, compare), one for the quadrant.
// Seven cells binary-search the truncated angle, one bit each.
// busy is high only during reset and the cycle after it.
// Synchronous active-low reset clears the valid bits; the result
// port is never held off, so nothing in the pipe stalls.
module heading_angle_from_two_points (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  hatp_pkg::t_item     i_item,
    output logic                o_strobe,
    output hatp_pkg::t_result   o_result
);
    import hatp_pkg::*;

    localparam int PIPE_LAT = 2 * K_W + 2;

    logic               r_live;
    logic               take;

    logic               c_valid [0:K_W];
    logic [COORD_W-1:0] c_a     [0:K_W];
    logic [COORD_W-1:0] c_b     [0:K_W];
    logic [K_W-1:0]     c_k     [0:K_W];
    t_side              c_side  [0:K_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign busy = ~r_live;
    assign take = start && !busy;

    hatp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(take),
        .i_item (i_item),
        .o_valid(c_valid[0]),
        .o_a    (c_a[0]),
        .o_b    (c_b[0]),
        .o_side (c_side[0])
    );

    assign c_k[0] = '0;

    for (genvar g = 0; g < K_W; g++) begin : g_cell
        hatp_cell #(
            .BIT(K_W - 1 - g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(c_valid[g]),
            .i_a    (c_a[g]),
            .i_b    (c_b[g]),
            .i_k    (c_k[g]),
            .i_side (c_side[g]),
            .o_valid(c_valid[g+1]),
            .o_a    (c_a[g+1]),
            .o_b    (c_b[g+1]),
            .o_k    (c_k[g+1]),
            .o_side (c_side[g+1])
        );
    end

    hatp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[K_W]),
        .i_k     (c_k[K_W]),
        .i_side  (c_side[K_W]),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##PIPE_LAT o_strobe)
        else $error("item did not come out after the pipeline latency");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.heading_valid |-> o_result.heading_deg == '0)
        else $error("invalid heading not zero");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.heading_valid |-> o_result.heading_deg <= DEG_360)
        else $error("heading out of range");

endmodule

// ===== bench/heading_checker.sv =====
`timescale 1ns / 1ps

module heading_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  hatp_pkg::t_item   i_item,
    input  logic              i_strobe,
    input  hatp_pkg::t_result i_result,
    output int                o_pending,
    output int                o_mismatches
);
    import hatp_pkg::*;

    localparam t_q62 ONE_Q62    = 64'h4000_0000_0000_0000;
    localparam t_q62 HALF_TURN  = 64'hC90F_DAA2_2168_C234;
    localparam int   MAX_TRUNC  = 89;
    localparam int   EXACT_DIAG = 45;
    localparam int   REPORT_MAX = 10;
    localparam int   ANG_UP     = 90;
    localparam int   ANG_DOWN   = -90;
    localparam int   ANG_HALF   = 180;
    localparam int   ANG_FULL   = 360;

    t_q62    cos_q [0:90];
    t_q62    sin_q [0:90];
    t_result want_headings [$];
    int      fails = 0;

    function automatic t_q62 q62_mul(input t_q62 x, input t_q62 y);
        logic [127:0] p;
        p = 128'(x) * 128'(y);
        return t_q62'(p >> 62);
    endfunction

    // cos/sin of whole degrees in Q2.62, by repeated one-degree rotation
    initial begin
        t_q62 step;
        t_q62 step2;
        t_q62 s1;
        t_q62 c1;
        t_q62 ts;
        t_q62 tc;
        step  = HALF_TURN / t_q62'(180);
        step2 = q62_mul(step, step);
        s1    = step;
        c1    = ONE_Q62;
        ts    = step;
        tc    = ONE_Q62;
        for (int n = 1; n <= 10; n++) begin
            ts = q62_mul(ts, step2) / t_q62'((2 * n) * (2 * n + 1));
            tc = q62_mul(tc, step2) / t_q62'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                s1 = s1 - ts;
                c1 = c1 - tc;
            end else begin
                s1 = s1 + ts;
                c1 = c1 + tc;
            end
        end
        cos_q[0] = ONE_Q62;
        sin_q[0] = '0;
        for (int k = 0; k < 90; k++) begin
            cos_q[k + 1] = q62_mul(cos_q[k], c1) - q62_mul(sin_q[k], s1);
            sin_q[k + 1] = q62_mul(sin_q[k], c1) + q62_mul(cos_q[k], s1);
        end
    end

    // largest k in 0..89 with rise*cos(k) >= run*sin(k)
    function automatic int trunc_degrees(input logic [COORD_W-1:0] rise,
                                         input logic [COORD_W-1:0] run);
        int           k;
        logic         ok;
        logic [127:0] lhs;
        logic [127:0] rhs;
        k  = 0;
        ok = 1'b1;
        while (ok && k < MAX_TRUNC) begin
            if (k + 1 == EXACT_DIAG) begin
                ok = (rise >= run);
            end else begin
                lhs = 128'(rise) * 128'(cos_q[k + 1]);
                rhs = 128'(run) * 128'(sin_q[k + 1]);
                ok  = (lhs >= rhs);
            end
            if (ok) begin
                k++;
            end
        end
        return k;
    endfunction

    function automatic t_result predict_heading(input t_item it);
        int      dx;
        int      dy;
        int      ang;
        t_result r;
        dx = int'(it.front_x) - int'(it.back_x);
        dy = int'(it.front_y) - int'(it.back_y);
        r  = '0;
        if (dx == 0 && dy == 0) begin
            return r;
        end
        if (dx == 0) begin
            ang = (dy > 0) ? ANG_UP : ANG_DOWN;
        end else begin
            ang = trunc_degrees(COORD_W'(dy < 0 ? -dy : dy), COORD_W'(dx < 0 ? -dx : dx));
            if ((dx < 0) != (dy < 0) && dy != 0) begin
                ang = -ang;
            end
        end
        if (dx < 0) begin
            ang += ANG_HALF;
        end else if (dy <= 0) begin
            ang += ANG_FULL;
        end
        if (ang > ANG_FULL) begin
            ang -= ANG_FULL;
        end
        r.heading_deg   = DEG_W'(ang);
        r.heading_valid = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            o_pending    <= 0;
            o_mismatches <= fails;
        end else begin
            if (i_strobe) begin
                if (want_headings.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX) begin
                        $display("%0t: unexpected heading deg=%0d valid=%0b", $realtime,
                                 i_result.heading_deg, i_result.heading_valid);
                    end
                end else begin
                    want = want_headings.pop_front();
                    if (want.heading_deg !== i_result.heading_deg ||
                        want.heading_valid !== i_result.heading_valid) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display({"%0t: heading mismatch: expected deg=%0d valid=%0b,",
                                      " got deg=%0d valid=%0b"},
                                     $realtime, want.heading_deg, want.heading_valid,
                                     i_result.heading_deg, i_result.heading_valid);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                want_headings.push_back(predict_heading(i_item));
            end
            o_pending    <= want_headings.size();
            o_mismatches <= fails;
        end
    end

endmodule

// ===== bench/heading_angle_from_two_points_tb.sv =====
`timescale 1ns / 1ps

module heading_angle_from_two_points_tb;

    import hatp_pkg::*;

    localparam int    COORD_MAX    = (1 << COORD_W) - 1;
    localparam int    RAND_ITEMS   = 400;
    localparam int    DRAIN_LIMIT  = 5000;
    localparam int    TAIL_CYCLES  = 24;
    localparam real   DEG_TO_RAD   = 3.14159265358979323846 / 180.0;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;
    int      pending_headings;
    int      mismatches;

    heading_angle_from_two_points dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    heading_checker u_heading_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .o_pending   (pending_headings),
        .o_mismatches(mismatches)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_item pts(input int fx, input int fy, input int bx, input int by);
        t_item it;
        it.front_x = COORD_W'(fx);
        it.front_y = COORD_W'(fy);
        it.back_x  = COORD_W'(bx);
        it.back_y  = COORD_W'(by);
        return it;
    endfunction

    // random back point such that back + delta stays on the grid
    function automatic t_item place_delta(input int dx, input int dy);
        int bx;
        int by;
        bx = (dx >= 0) ? $urandom_range(COORD_MAX - dx, 0) : $urandom_range(COORD_MAX, -dx);
        by = (dy >= 0) ? $urandom_range(COORD_MAX - dy, 0) : $urandom_range(COORD_MAX, -dy);
        return pts(bx + dx, by + dy, bx, by);
    endfunction

    function automatic t_item random_item();
        int  pick;
        int  dx;
        int  dy;
        int  k;
        int  tmp;
        real rise;
        pick = $urandom_range(99);
        if (pick < 30) begin
            return pts($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                       $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
        end
        if (pick < 40) begin
            dx = 0;
            dy = 0;
        end else if (pick < 50) begin
            dx = $urandom_range(COORD_MAX, 1);
            dy = 0;
            if ($urandom_range(1)) begin
                dy = dx;
                dx = 0;
            end
        end else if (pick < 60) begin
            dx = $urandom_range(COORD_MAX, 1);
            dy = dx;
        end else if (pick < 88) begin
            // just around tan of a whole degree
            k    = $urandom_range(89, 1);
            dx   = $urandom_range(COORD_MAX, 1);
            rise = dx * $tan(k * DEG_TO_RAD);
            dy   = $rtoi(rise) + $urandom_range(2) - 1;
            if (dy < 0 || dy > COORD_MAX) begin
                dy = $urandom_range(COORD_MAX);
            end
            if ($urandom_range(1)) begin
                tmp = dx;
                dx  = dy;
                dy  = tmp;
            end
        end else begin
            dx = $urandom_range(8);
            dy = $urandom_range(8);
        end
        if ($urandom_range(1)) begin
            dx = -dx;
        end
        if ($urandom_range(1)) begin
            dy = -dy;
        end
        return place_delta(dx, dy);
    endfunction

    task automatic drive_item(input t_item it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    initial begin
        int idle_pct [0:2];
        int drained;
        idle_pct[0] = 31;
        idle_pct[1] = 86;
        idle_pct[2] = 0;
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drive_item(pts(0, 0, 0, 0), 0);
        drive_item(pts(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 0);
        drive_item(pts(COORD_MAX, 0, 0, 0), 0);
        drive_item(pts(0, 0, COORD_MAX, 0), 0);
        drive_item(pts(0, COORD_MAX, 0, 0), 0);
        drive_item(pts(0, 0, 0, COORD_MAX), 0);
        drive_item(pts(COORD_MAX, COORD_MAX, 0, 0), 0);
        drive_item(pts(0, COORD_MAX, COORD_MAX, 0), 0);
        drive_item(pts(0, 0, COORD_MAX, COORD_MAX), 0);
        drive_item(pts(COORD_MAX, 0, 0, COORD_MAX), 0);
        drive_item(pts(1, 1, 0, 0), 0);
        drive_item(pts(COORD_MAX, COORD_MAX - 1, 0, 0), 0);
        drive_item(pts(COORD_MAX - 1, COORD_MAX, 0, 0), 0);
        drive_item(pts(COORD_MAX, 1, 0, 0), 0);
        drive_item(pts(1, COORD_MAX, 0, 0), 0);
        drive_item(pts(COORD_MAX, 71, 0, 0), 0);
        drive_item(pts(COORD_MAX, 72, 0, 0), 0);
        drive_item(pts(0, 1, COORD_MAX, 0), 0);
        drive_item(pts(2048, 2048, 2047, 2048), 0);
        drive_item(pts(2047, 2047, 2048, 2048), 0);
        drive_item(pts('hAAA, 'h555, 'h555, 'hAAA), 0);
        drive_item(pts('h555, 'hAAA, 'hAAA, 'h555), 0);

        for (int ph = 0; ph < 3; ph++) begin
            repeat (RAND_ITEMS / 3) drive_item(random_item(), idle_pct[ph]);
        end
        start <= 1'b0;
        @(posedge i_clk);

        drained = 0;
        while (pending_headings != 0 && drained < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drained++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_headings == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
